FILE: design/vnpo_pkg.sv
// Shared types, constants and the weight-table entry function for the value noise overlay.
// Depends on nothing; every other design file imports it.
package vnpo_pkg;

  // Fixed field widths
  localparam int CFG_W   = 24;
  localparam int OCT_W   = 4;
  localparam int PIX_W   = 24;
  localparam int SUM_W   = 40;
  localparam int SM_W    = 36;
  localparam int WGT_W   = 17;
  localparam int PR_W    = SM_W + WGT_W + 1;
  localparam int LVL_W   = 8;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FREQ_X  = 2'd0,
    REG_FREQ_Y  = 2'd1,
    REG_OCTAVES = 2'd2
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] FREQ_RESET    = 24'd2048;
  localparam logic [OCT_W-1:0] OCTAVES_RESET = 4'd4;

  // Lattice hash constants
  localparam logic [31:0] HASH_MUL  = 32'd15731;
  localparam logic [31:0] HASH_ADD1 = 32'd789221;
  localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
  localparam logic [31:0] LAT_ONE   = 32'd1073741824;
  localparam logic [31:0] YSTEP     = 32'd57;

  // Interpolation weight constants
  localparam logic [WGT_W-1:0] WGT_ONE    = 17'd65536;
  localparam logic [15:0]      BLEND_MASK = 16'hffff;
  localparam longint           Q30_ONE    = 64'sd1073741824;
  localparam longint           PI_Q30     = 64'sd3373259426;

  // Weight for table entry k in the lower half: (1 - cos(pi*k/N)) / 2 in Q1.16
  function automatic logic [WGT_W-1:0] half_weight(input longint k, input int ctb);
    longint      x;
    longint      x2;
    longint      t;
    longint      w30;
    longint      w16;
    logic [63:0] ux;
    x   = (PI_Q30 * k) >>> ctb;
    ux  = x;
    x2  = longint'((ux * ux) >> 30);
    t   = Q30_ONE;
    t   = Q30_ONE - ((x2 * t) / 132) / Q30_ONE;
    t   = Q30_ONE - ((x2 * t) / 90) / Q30_ONE;
    t   = Q30_ONE - ((x2 * t) / 56) / Q30_ONE;
    t   = Q30_ONE - ((x2 * t) / 30) / Q30_ONE;
    t   = Q30_ONE - ((x2 * t) / 12) / Q30_ONE;
    t   = Q30_ONE - ((x2 * t) / 2) / Q30_ONE;
    w30 = (Q30_ONE - t) / 2;
    if (w30 < 0) begin
      w30 = 0;
    end
    w16 = (w30 + 8192) >>> 14;
    if (w16 > 65536) begin
      w16 = 65536;
    end
    return WGT_W'(w16);
  endfunction

  // Divide a blend sum by 65536, truncating toward zero
  function automatic logic signed [SM_W-1:0] blend_div(input logic signed [PR_W:0] s);
    logic signed [PR_W:0] t;
    t = s + (s[PR_W] ? (PR_W+1)'(BLEND_MASK) : '0);
    return SM_W'(t >>> 16);
  endfunction

endpackage

FILE: design/vnpo_hash.sv
// Pipelined 32-bit lattice hash, four register stages, result in Q2.30.
// Depends on vnpo_pkg for the hash constants.
module vnpo_hash import vnpo_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        m_i,
  output logic signed [31:0] lat_o
);

  logic [31:0] sq_q, m1_q, t_q, m2_q, p_q;
  logic [31:0] h;
  logic signed [31:0] lat_q;

  assign h = p_q + HASH_ADD2;

  // Advance the multiply chain: n*n, then *15731+789221, then n*t
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= m_i * m_i;
      m1_q  <= m_i;
      t_q   <= sq_q * HASH_MUL + HASH_ADD1;
      m2_q  <= m1_q;
      p_q   <= m2_q * t_q;
      lat_q <= $signed(LAT_ONE - {1'b0, h[30:0]});
    end
  end

  assign lat_o = lat_q;

endmodule

FILE: design/vnpo_cell.sv
// One octave cell: hashes a 4x4 lattice patch, smooths four corners, blends them
// and adds the scaled octave to the running sum. Uses vnpo_pkg and vnpo_hash.
module vnpo_cell import vnpo_pkg::*; #(
  parameter int OCT = 0,
  parameter int PW  = 36,
  parameter int CTB = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    oct_en_i,
  input  logic                    vld_i,
  input  logic [PW-1:0]           px_i,
  input  logic [PW-1:0]           py_i,
  input  logic [PIX_W-1:0]        pix_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output logic                    vld_o,
  output logic [PW-1:0]           px_o,
  output logic [PW-1:0]           py_o,
  output logic [PIX_W-1:0]        pix_o,
  output logic signed [SUM_W-1:0] sum_o
);

  localparam int TAB_N = 1 << CTB;
  localparam int NPIPE = 9;
  localparam int TOKW  = SUM_W + 2 * PW + PIX_W;

  typedef logic [WGT_W-1:0] wtab_t [TAB_N];

  function automatic wtab_t build_wtab();
    wtab_t tab;
    for (int k = 0; k < TAB_N; k++) begin
      if (2 * k <= TAB_N) begin
        tab[k] = half_weight(longint'(k), CTB);
      end else begin
        tab[k] = WGT_ONE - half_weight(longint'(TAB_N - k), CTB);
      end
    end
    return tab;
  endfunction

  localparam wtab_t WTAB = build_wtab();

  // Entry: scale coordinates for this octave, split integer and fraction
  logic [63:0]      px_ext, py_ext;
  logic [31:0]      ix, iy, base;
  logic [CTB-1:0]   idx_x, idx_y;
  logic [31:0]      m_d [16];
  logic [31:0]      m_q [16];
  logic signed [31:0] lat [16];

  assign px_ext = 64'(px_i) << OCT;
  assign py_ext = 64'(py_i) << OCT;
  assign ix     = px_ext[47:16];
  assign iy     = py_ext[47:16];
  assign idx_x  = px_ext[15 -: CTB];
  assign idx_y  = py_ext[15 -: CTB];
  assign base   = ix + iy * YSTEP;

  for (genvar g = 0; g < 16; g++) begin : g_pt
    localparam int DX = g % 4 - 1;
    localparam int DY = g / 4 - 1;
    logic [31:0] n;
    assign n      = base + 32'(DX) + 32'(57 * DY);
    assign m_d[g] = (n << 13) ^ n;

    vnpo_hash u_hash (
      .clk_i (clk_i),
      .en_i  (en_i),
      .m_i   (m_q[g]),
      .lat_o (lat[g])
    );
  end

  // Stage 1: register hash seeds and look up both weights
  logic [WGT_W-1:0] wx_q [6];
  logic [WGT_W-1:0] wy_q [8];
  logic             vld_q [NPIPE];
  logic [TOKW-1:0]  tok_q [NPIPE];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < 16; g++) begin
        m_q[g] <= m_d[g];
      end
      wx_q[0] <= WTAB[idx_x];
      wy_q[0] <= WTAB[idx_y];
      for (int i = 1; i < 6; i++) begin
        wx_q[i] <= wx_q[i-1];
      end
      for (int i = 1; i < 8; i++) begin
        wy_q[i] <= wy_q[i-1];
      end
      tok_q[0] <= {sum_i, px_i, py_i, pix_i};
      for (int i = 1; i < NPIPE; i++) begin
        tok_q[i] <= tok_q[i-1];
      end
    end
  end

  // Carry the request valid alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NPIPE; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < NPIPE; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Stage 6: 3x3 smoothing at the four corners
  logic signed [SM_W-1:0] sm_d [4];
  logic signed [SM_W-1:0] sm_q [4];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    localparam int A = c % 2 + 1;
    localparam int B = c / 2 + 1;
    logic signed [SM_W-1:0] cs, ss, ce;
    assign cs = SM_W'(lat[(B-1)*4 + A-1]) + SM_W'(lat[(B-1)*4 + A+1])
              + SM_W'(lat[(B+1)*4 + A-1]) + SM_W'(lat[(B+1)*4 + A+1]);
    assign ss = SM_W'(lat[B*4 + A-1]) + SM_W'(lat[B*4 + A+1])
              + SM_W'(lat[(B-1)*4 + A]) + SM_W'(lat[(B+1)*4 + A]);
    assign ce = SM_W'(lat[B*4 + A]);
    assign sm_d[c] = cs + (ss <<< 1) + (ce <<< 2);
  end

  // Stages 7 to 9: blend along x, then along y
  logic signed [WGT_W:0]  wxs, wxc, wys, wyc;
  logic signed [PR_W-1:0] pa1_q, pb1_q, pa2_q, pb2_q, pc_q, pd_q;
  logic signed [SM_W-1:0] i1_q, i2_q;

  assign wxs = $signed({1'b0, wx_q[5]});
  assign wxc = $signed({1'b0, WGT_ONE - wx_q[5]});
  assign wys = $signed({1'b0, wy_q[7]});
  assign wyc = $signed({1'b0, WGT_ONE - wy_q[7]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        sm_q[c] <= sm_d[c];
      end
      pa1_q <= sm_q[0] * wxc;
      pb1_q <= sm_q[1] * wxs;
      pa2_q <= sm_q[2] * wxc;
      pb2_q <= sm_q[3] * wxs;
      i1_q  <= blend_div((PR_W+1)'(pa1_q) + (PR_W+1)'(pb1_q));
      i2_q  <= blend_div((PR_W+1)'(pa2_q) + (PR_W+1)'(pb2_q));
      pc_q  <= i1_q * wyc;
      pd_q  <= i2_q * wys;
    end
  end

  // Stage 10: scale the octave down and accumulate
  logic signed [SM_W-1:0]  v, vr, term;
  logic [SM_W-1:0]         rnd;
  logic signed [SUM_W-1:0] sum_in;
  logic [PW-1:0]           px_p, py_p;
  logic [PIX_W-1:0]        pix_p;

  assign {sum_in, px_p, py_p, pix_p} = tok_q[NPIPE-1];
  assign v    = blend_div((PR_W+1)'(pc_q) + (PR_W+1)'(pd_q));
  assign rnd  = v[SM_W-1] ? SM_W'((64'd1 << OCT) - 64'd1) : '0;
  assign vr   = v + rnd;
  assign term = vr >>> OCT;

  logic                    vld_out_q;
  logic [PW-1:0]           px_out_q, py_out_q;
  logic [PIX_W-1:0]        pix_out_q;
  logic signed [SUM_W-1:0] sum_out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_out_q  <= px_p;
      py_out_q  <= py_p;
      pix_out_q <= pix_p;
      sum_out_q <= sum_in + (oct_en_i ? SUM_W'(term) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[NPIPE-1];
    end
  end

  assign vld_o = vld_out_q;
  assign px_o  = px_out_q;
  assign py_o  = py_out_q;
  assign pix_o = pix_out_q;
  assign sum_o = sum_out_q;

endmodule

FILE: design/value_noise_pixel_overlay_core.sv
// Top level of the value noise pixel overlay: config registers, coordinate scaling,
// the chain of octave cells, level mapping and output skid. Uses vnpo_pkg, vnpo_cell.
//
// Takes one pixel per clock and returns one pixel per clock while the skid entry is
// free; a full skid entry stalls the input. A request passes a coordinate multiply
// stage, one cell per octave (MAX_OCTAVES cells of ten stages each, set by the weight
// table read, the three-multiply hash and the two blends), a level stage and the
// output register before the result is presented.
// A two-entry output stage lets one finished pixel wait while input continues.
module value_noise_pixel_overlay_core import vnpo_pkg::*; #(
  parameter int MAX_OCTAVES    = 8,
  parameter int COORD_BITS     = 12,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  // col[11:0], row[23:12], src_red[31:24], src_green[39:32], src_blue[47:40]
  input  logic [47:0]      s_tdata_i,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  // out_red[7:0], out_green[15:8], out_blue[23:16], noise_level[31:24]
  output logic [31:0]      m_tdata_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int CW  = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam int PW  = CW + CFG_W;
  localparam int NOW = $clog2(MAX_OCTAVES + 1);

  // Configuration registers
  logic [CFG_W-1:0] freq_x_q, freq_y_q;
  logic [OCT_W-1:0] octaves_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_x_q  <= FREQ_RESET;
      freq_y_q  <= FREQ_RESET;
      octaves_q <= OCTAVES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FREQ_X:  freq_x_q  <= cfg_wdata_i;
        REG_FREQ_Y:  freq_y_q  <= cfg_wdata_i;
        REG_OCTAVES: octaves_q <= cfg_wdata_i[OCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the octave count
  logic [NOW-1:0] nocts;
  assign nocts = (32'(octaves_q) > MAX_OCTAVES) ? NOW'(MAX_OCTAVES) : NOW'(octaves_q);

  // Pipeline advances unless the skid entry is occupied
  logic en, skid_vld_q, out_vld_q;
  assign en         = !skid_vld_q;
  assign s_tready_o = en;

  // Chain links
  logic                    vld_c [MAX_OCTAVES+1];
  logic [PW-1:0]           px_c  [MAX_OCTAVES+1];
  logic [PW-1:0]           py_c  [MAX_OCTAVES+1];
  logic [PIX_W-1:0]        pix_c [MAX_OCTAVES+1];
  logic signed [SUM_W-1:0] sum_c [MAX_OCTAVES+1];

  // Stage 0: scale coordinates by the frequencies
  logic [PW-1:0]    px0_q, py0_q;
  logic [PIX_W-1:0] pix0_q;
  logic             vld0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px0_q  <= PW'(s_tdata_i[CW-1:0]) * PW'(freq_x_q);
      py0_q  <= PW'(s_tdata_i[12 +: CW]) * PW'(freq_y_q);
      pix0_q <= s_tdata_i[47:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= s_tvalid_i;
    end
  end

  assign vld_c[0] = vld0_q;
  assign px_c[0]  = px0_q;
  assign py_c[0]  = py0_q;
  assign pix_c[0] = pix0_q;
  assign sum_c[0] = '0;

  for (genvar f = 0; f < MAX_OCTAVES; f++) begin : g_cell
    logic oct_en;
    assign oct_en = (NOW'(f) < nocts);

    vnpo_cell #(
      .OCT (f),
      .PW  (PW),
      .CTB (COS_TABLE_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .oct_en_i (oct_en),
      .vld_i    (vld_c[f]),
      .px_i     (px_c[f]),
      .py_i     (py_c[f]),
      .pix_i    (pix_c[f]),
      .sum_i    (sum_c[f]),
      .vld_o    (vld_c[f+1]),
      .px_o     (px_c[f+1]),
      .py_o     (py_c[f+1]),
      .pix_o    (pix_c[f+1]),
      .sum_o    (sum_c[f+1])
    );
  end

  // Level stage: clamp to [-1, 1] and map to a byte
  localparam logic signed [SUM_W-1:0] LIM = SUM_W'(64'd1 << 34);
  logic signed [SUM_W-1:0] r, rc;
  logic [35:0]             rs;
  logic [43:0]             scaled;
  logic [LVL_W-1:0]        lvl_d, fin_lvl_q;
  logic [PIX_W-1:0]        fin_pix_q;
  logic                    fin_vld_q;

  assign r      = sum_c[MAX_OCTAVES];
  assign rc     = (r > LIM) ? LIM : ((r < -LIM) ? -LIM : r);
  assign rs     = 36'(rc + LIM);
  assign scaled = (44'(rs) << 8) - 44'(rs);
  assign lvl_d  = scaled[42:35];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_lvl_q <= lvl_d;
      fin_pix_q <= pix_c[MAX_OCTAVES];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (en) begin
      fin_vld_q <= vld_c[MAX_OCTAVES];
    end
  end

  // Build the output word
  logic [31:0] res_d;
  assign res_d = {fin_lvl_q,
                  fin_pix_q[23:16] + fin_lvl_q,
                  fin_pix_q[15:8] + fin_lvl_q,
                  fin_pix_q[7:0] + fin_lvl_q};

  // Output register with skid entry
  logic [31:0] out_q, skid_q;
  logic        push, pop;
  assign push = en && fin_vld_q;
  assign pop  = out_vld_q && m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_q;

  // Skid entry only holds data behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid entry valid without output");

  // Input is closed while the skid entry is in use
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !s_tready_o) else $error("input open with skid full");

  // Draining the skid entry keeps the output valid
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && m_tready_i) |=> (out_vld_q && !skid_vld_q))
    else $error("skid drain lost a result");

endmodule
